@@ rtl/core/ovc_pkg.sv @@
package ovc_pkg;

   // encode group stack: a 64-bit value needs at most ten 7-bit groups
   localparam int STACK_DEPTH = 10;
   localparam int SP_W        = 4;

   localparam logic [7:0] GROUP_MASK = 8'h7F;
   localparam logic [7:0] CONT_BIT   = 8'h80;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } ovc_op_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_FAIL  = 2'd2
   } ovc_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SPLIT = 2'd1,
      ST_EMIT  = 2'd2
   } ovc_state_type;

   // one queued item, classified by the front end
   typedef struct packed {
      ovc_op_type  op;
      logic [63:0] plain_value;
      logic [7:0]  in_byte;
      logic        is_cont;     // decode byte carries the continuation bit
      logic        buffer_end;
   } ovc_item_type;

   typedef struct packed {
      ovc_kind_type kind;
      logic [7:0]   out_byte;
      logic [63:0]  decoded_value;
      logic         last;
   } ovc_rsp_type;

endpackage

@@ rtl/core/ovc_front.sv @@
module ovc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [71:0]          req_tdata,
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   output logic                 q_valid,
   output ovc_pkg::ovc_item_type q_item,
   input  logic                 q_pop
);

   // two-entry queue between front and back
   ovc_pkg::ovc_item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   ovc_pkg::ovc_item_type item_new;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      item_new.op          = req_tuser ? ovc_pkg::OP_DECODE : ovc_pkg::OP_ENCODE;
      item_new.plain_value = req_tdata[63:0];
      item_new.in_byte     = req_tdata[71:64];
      item_new.is_cont     = (req_tdata[71:64] & ovc_pkg::CONT_BIT) != 8'h00;
      item_new.buffer_end  = req_tlast;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

@@ rtl/core/ovc_back.sv @@
module ovc_back #(
   parameter int MAX_BYTES = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  ovc_pkg::ovc_item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ovc_pkg::ovc_rsp_type  rsp
);

   localparam int SEEN_W = $clog2(MAX_BYTES);

   ovc_pkg::ovc_state_type state_ff, state_in;

   logic [63:0]             acc_ff, acc_in;
   logic [SEEN_W-1:0]       seen_ff, seen_in;
   logic [63:0]             rem_ff, rem_in;
   logic [ovc_pkg::SP_W-1:0] cnt_ff, cnt_in;
   logic [7:0]              stack_ff [ovc_pkg::STACK_DEPTH];

   logic                    rsp_valid_ff, rsp_valid_in;
   ovc_pkg::ovc_rsp_type    rsp_ff, rsp_in;

   logic                    stk_we;
   logic [ovc_pkg::SP_W-1:0] stk_wa;
   logic [7:0]              stk_wd;

   logic                    out_free;
   logic [63:0]             acc_shift;
   logic [63:0]             rem_dec;
   logic [SEEN_W:0]         seen_next;
   logic [ovc_pkg::SP_W-1:0] rd_idx;
   logic                    split_done;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign acc_shift = {acc_ff[56:0], q_item.in_byte[6:0]};
   assign rem_dec   = rem_ff - 64'd1;
   assign seen_next = {1'b0, seen_ff} + {{SEEN_W{1'b0}}, 1'b1};
   assign rd_idx    = cnt_ff - {{(ovc_pkg::SP_W-1){1'b0}}, 1'b1};
   assign split_done = (rem_ff == 64'd0) ||
                       (cnt_ff == ovc_pkg::SP_W'(ovc_pkg::STACK_DEPTH));

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ovc_pkg::ST_IDLE: begin
            if (q_valid && q_item.op == ovc_pkg::OP_ENCODE) begin
               state_in = ovc_pkg::ST_SPLIT;
            end
         end
         ovc_pkg::ST_SPLIT: begin
            if (split_done) begin
               state_in = ovc_pkg::ST_EMIT;
            end
         end
         ovc_pkg::ST_EMIT: begin
            if (out_free && cnt_ff == {{(ovc_pkg::SP_W-1){1'b0}}, 1'b1}) begin
               state_in = ovc_pkg::ST_IDLE;
            end
         end
         default: state_in = ovc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      acc_in       = acc_ff;
      seen_in      = seen_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      stk_we       = 1'b0;
      stk_wa       = cnt_ff;
      stk_wd       = 8'h00;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ovc_pkg::ST_IDLE: begin
            if (q_valid && q_item.op == ovc_pkg::OP_ENCODE) begin
               q_pop  = 1'b1;
               stk_we = 1'b1;
               stk_wa = '0;
               stk_wd = q_item.plain_value[7:0] & ovc_pkg::GROUP_MASK;
               rem_in = {7'd0, q_item.plain_value[63:7]};
               cnt_in = {{(ovc_pkg::SP_W-1){1'b0}}, 1'b1};
            end else if (q_valid && out_free) begin
               q_pop = 1'b1;
               rsp_in.out_byte      = 8'h00;
               rsp_in.decoded_value = 64'd0;
               rsp_in.last          = 1'b1;
               if (!q_item.is_cont) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.kind          = ovc_pkg::KIND_VALUE;
                  rsp_in.decoded_value = acc_shift;
                  acc_in               = 64'd0;
                  seen_in              = '0;
               end else if (q_item.buffer_end ||
                            seen_next >= (SEEN_W+1)'(MAX_BYTES)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind  = ovc_pkg::KIND_FAIL;
                  acc_in       = 64'd0;
                  seen_in      = '0;
               end else begin
                  acc_in  = acc_shift + 64'd1;
                  seen_in = seen_next[SEEN_W-1:0];
               end
            end
         end
         ovc_pkg::ST_SPLIT: begin
            if (!split_done) begin
               stk_we = 1'b1;
               stk_wa = cnt_ff;
               stk_wd = (rem_dec[7:0] & ovc_pkg::GROUP_MASK) | ovc_pkg::CONT_BIT;
               rem_in = {7'd0, rem_dec[63:7]};
               cnt_in = cnt_ff + {{(ovc_pkg::SP_W-1){1'b0}}, 1'b1};
            end
         end
         ovc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = ovc_pkg::KIND_BYTE;
               rsp_in.out_byte      = stack_ff[rd_idx];
               rsp_in.decoded_value = 64'd0;
               rsp_in.last          = (cnt_ff == {{(ovc_pkg::SP_W-1){1'b0}}, 1'b1});
               cnt_in               = rd_idx;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ovc_pkg::ST_IDLE;
         acc_ff       <= 64'd0;
         seen_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
      if (stk_we) begin
         stack_ff[stk_wa] <= stk_wd;
      end
   end

endmodule

@@ rtl/core/offset_varint_codec.sv @@
// Offset 7-bit varint codec (each continuation group offset by one).
// Request channel (req_*): tuser selects the operation (0 encode, 1 decode),
//   tdata carries the value to encode and the byte to decode, tlast marks the
//   last byte available in the decode buffer.
// Response channel (rsp_*): tuser gives the kind (0 encoded byte, 1 decoded
//   value, 2 decode failure), tlast marks the final transfer of an item.
// A two-entry queue separates the accepting front end from the engine, so
//   requests keep being taken while the engine or the receiver is busy.
// Decode: one byte per transfer; a result, if any, is registered in the
//   queue and then in the response register before it shows on rsp. The
//   decoder state survives interleaved encodes.
// Encode of an n-byte result (n = 1..10): the value is split into groups
//   on a small stack, one 64-bit decrement per group after the first, the
//   split is closed, then one byte per cycle goes out from the stack while
//   the receiver takes them, most significant group first. Decodes run at
//   one byte per cycle while no encode runs and the receiver keeps up.
// Reset clears the queue, the decoder accumulator and byte count and the response valid flag.
// When the receiver holds rsp_tready low the response register holds its
//   transfer, the engine waits, and the queue fills; req_tready then falls.
module offset_varint_codec #(
   parameter int MAX_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // plain_value[63:0], in_byte[71:64]
   input  logic        req_tuser,   // op
   input  logic        req_tlast,   // buffer_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_byte[7:0], decoded_value[71:8]
   output logic [1:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last
);

   logic                  q_valid;
   logic                  q_pop;
   ovc_pkg::ovc_item_type q_item;
   ovc_pkg::ovc_rsp_type  rsp;

   ovc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   ovc_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // pack the response transfer
   assign rsp_tdata = {rsp.decoded_value, rsp.out_byte};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

@@ sim/ovc_varint_checker.sv @@
module ovc_varint_checker #(
   parameter int MAX_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [71:0] req_tdata,   // plain_value[63:0], in_byte[71:64]
   input  logic        req_tuser,   // op
   input  logic        req_tlast,   // buffer_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // out_byte[7:0], decoded_value[71:8]
   input  logic [1:0]  rsp_tuser,   // result_kind
   input  logic        rsp_tlast,   // last
   output int unsigned mismatch_count,
   output int unsigned results_owed
);

   ovc_pkg::ovc_rsp_type results_awaited[$];
   logic [63:0]   dec_acc;
   logic [3:0]    dec_count;
   int unsigned   fails;

   task automatic push_result(input ovc_pkg::ovc_kind_type kind, input logic [7:0] grp,
                              input logic [63:0] value, input logic fin);
      ovc_pkg::ovc_rsp_type r;
      r.kind          = kind;
      r.out_byte      = grp;
      r.decoded_value = value;
      r.last          = fin;
      results_awaited.push_back(r);
   endtask

   // split into offset groups, then emit most significant group first
   task automatic predict_encode(input logic [63:0] value);
      logic [63:0] v;
      logic [7:0]  grp [ovc_pkg::STACK_DEPTH];
      int          n;
      v      = value;
      grp[0] = {1'b0, v[6:0]};
      v      = v >> 7;
      n      = 1;
      while (v != 64'd0 && n < ovc_pkg::STACK_DEPTH) begin
         v      = v - 64'd1;
         grp[n] = {1'b1, v[6:0]};
         v      = v >> 7;
         n++;
      end
      for (int i = n - 1; i >= 0; i--)
         push_result(ovc_pkg::KIND_BYTE, grp[i], 64'd0, i == 0);
   endtask

   task automatic predict_decode(input logic [7:0] b, input logic at_end);
      logic [63:0] acc;
      acc = {dec_acc[56:0], 7'd0} | {57'd0, b[6:0]};
      if (!b[7]) begin
         push_result(ovc_pkg::KIND_VALUE, 8'd0, acc, 1'b1);
         dec_acc   = 64'd0;
         dec_count = 4'd0;
      end else if (at_end || int'(dec_count) + 1 >= MAX_BYTES) begin
         // buffer ran out or too many bytes: fail and start afresh
         push_result(ovc_pkg::KIND_FAIL, 8'd0, 64'd0, 1'b1);
         dec_acc   = 64'd0;
         dec_count = 4'd0;
      end else begin
         dec_acc   = acc + 64'd1;
         dec_count = dec_count + 4'd1;
      end
   endtask

   always @(posedge clock) begin
      ovc_pkg::ovc_rsp_type exp_rsp;
      if (reset) begin
         dec_acc   = 64'd0;
         dec_count = 4'd0;
         fails     = 0;
         results_awaited.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (req_tuser == ovc_pkg::OP_ENCODE)
               predict_encode(req_tdata[63:0]);
            else
               predict_decode(req_tdata[71:64], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (results_awaited.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected result kind %0d byte %02h value %016h last %b",
                           $time, rsp_tuser, rsp_tdata[7:0], rsp_tdata[71:8], rsp_tlast);
            end else begin
               exp_rsp = results_awaited.pop_front();
               if (rsp_tuser !== exp_rsp.kind || rsp_tdata[7:0] !== exp_rsp.out_byte ||
                   rsp_tdata[71:8] !== exp_rsp.decoded_value ||
                   rsp_tlast !== exp_rsp.last) begin
                  fails++;
                  if (fails <= 10) begin
                     $display("%0t: result mismatch, expected kind %0d byte %02h value %016h last %b",
                              $time, exp_rsp.kind, exp_rsp.out_byte,
                              exp_rsp.decoded_value, exp_rsp.last);
                     $display("   got kind %0d byte %02h value %016h last %b",
                              rsp_tuser, rsp_tdata[7:0], rsp_tdata[71:8], rsp_tlast);
                  end
               end
            end
         end
      end
      mismatch_count <= fails;
      results_owed   <= results_awaited.size();
   end

endmodule

@@ sim/offset_varint_codec_tb.sv @@
module offset_varint_codec_tb;

   localparam int MAX_BYTES    = 10;
   localparam int RANDOM_ITEMS = 85;
   // no-transfer cycles tolerated: far beyond the longest stall plus a full encode
   localparam int IDLE_LIMIT   = 2000;
   // drain time after the last expected transfer
   localparam int DRAIN_CYCLES = 50;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;     // plain_value[63:0], in_byte[71:64]
   logic        req_tuser;     // op
   logic        req_tlast;     // buffer_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;     // out_byte[7:0], decoded_value[71:8]
   logic [1:0]  rsp_tuser;     // result_kind
   logic        rsp_tlast;     // last

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned items_sent;
   int unsigned quiet_items;
   int unsigned idle_cycles;

   offset_varint_codec #(
      .MAX_BYTES (MAX_BYTES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predicts every transfer on rsp from the transfers on req and compares
   ovc_varint_checker #(
      .MAX_BYTES (MAX_BYTES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver pacing: ready and stall stretches alternate. Stall lengths are
   // drawn at random, one time in five from a much longer range; ready stretches
   // now and then run long enough to let whole encodes out without a gap.
   always @(posedge clock) begin : rsp_pacing
      int unsigned phase_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         phase_left = 0;
      end else if (phase_left == 0) begin
         if (rsp_tready) begin
            rsp_tready <= 1'b0;
            phase_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b1;
            phase_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
         end
      end else begin
         phase_left--;
      end
   end

   // Watchdog: a run of cycles with no transfer on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [63:0] rand_value();
      // shift a full random word down so short encodings are well represented
      return {$urandom, $urandom} >> $urandom_range(0, 63);
   endfunction

   // One request transfer. Entered at a rising edge, returns at the edge on
   // which the transfer took place, so a back-to-back item is driven in the
   // same step without lowering tvalid in between.
   task automatic send_req(input ovc_pkg::ovc_op_type op, input logic [63:0] value,
                           input logic [7:0] in_byte, input logic at_end);
      int unsigned gap;
      if (quiet_items != 0) begin
         quiet_items--;
         gap = 0;
      end else if ($urandom_range(0, 14) == 0) begin
         quiet_items = $urandom_range(8, 16);
         gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
         gap = $urandom_range(10, 40);
      end else if ($urandom_range(0, 1) == 0) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = 0;
      end
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {in_byte, value};
      req_tlast  <= at_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   initial begin
      int unsigned base;
      int unsigned seq_len;
      int unsigned pick;
      logic [7:0]  seq_byte;
      logic        at_end;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      items_sent  = 0;
      quiet_items = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed: encode extremes and group boundaries ---
      send_req(ovc_pkg::OP_ENCODE, 64'd0, 8'hFF, 1'b1);
      send_req(ovc_pkg::OP_ENCODE, 64'd127, 8'h00, 1'b0);
      send_req(ovc_pkg::OP_ENCODE, 64'd128, 8'hA5, 1'b0);        // first two-byte value
      send_req(ovc_pkg::OP_ENCODE, 64'd16511, 8'h5A, 1'b1);      // last two-byte value
      send_req(ovc_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0);  // ten bytes
      send_req(ovc_pkg::OP_ENCODE, 64'h8000_0000_0000_0000, 8'hFF, 1'b1);

      // --- directed: decode ---
      // final byte that is also the buffer end gives a value, not a failure
      send_req(ovc_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b1);
      send_req(ovc_pkg::OP_DECODE, 64'd0, 8'h7F, 1'b0);
      // continuation byte mid-buffer: nothing out, partial value kept
      send_req(ovc_pkg::OP_DECODE, 64'd0, 8'h80, 1'b0);
      // an encode in the middle must leave the partial decode alone
      send_req(ovc_pkg::OP_ENCODE, 64'h5555_AAAA_5555_AAAA, 8'h80, 1'b0);
      send_req(ovc_pkg::OP_DECODE, 64'd0, 8'h00, 1'b0);          // completes to 128
      // buffer runs out inside a value
      send_req(ovc_pkg::OP_DECODE, 64'd0, 8'hFF, 1'b1);
      // byte limit: the tenth continuation byte fails at once
      repeat (MAX_BYTES) send_req(ovc_pkg::OP_DECODE, 64'd0, 8'hFF, 1'b0);

      // --- random: mostly well-formed decode runs, some encodes and noise ---
      base = items_sent;
      while (items_sent < base + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            send_req(ovc_pkg::OP_ENCODE, rand_value(), 8'($urandom), 1'($urandom));
         end else if (pick < 8) begin
            // lengths up to eleven: ten bytes wrap the accumulator, eleven
            // runs into the byte limit before the final byte
            seq_len = $urandom_range(1, MAX_BYTES + 1);
            for (int k = 1; k <= seq_len; k++) begin
               seq_byte = {(k != seq_len), 7'($urandom)};
               at_end   = (k == seq_len) ? 1'($urandom) : ($urandom_range(0, 19) == 0);
               send_req(ovc_pkg::OP_DECODE, {$urandom, $urandom}, seq_byte, at_end);
               if ($urandom_range(0, 19) == 0)
                  send_req(ovc_pkg::OP_ENCODE, rand_value(), 8'($urandom), 1'($urandom));
            end
         end else begin
            send_req(ovc_pkg::OP_DECODE, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      // let the checker see the last transfer, drain, then allow for strays
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && results_owed == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
